// ----- rtl/ftws_pkg.sv -----
// Shared types, widths and constants of the frame-time window statistics block.
`default_nettype none

package ftws_pkg;

  // Field widths
  localparam int TS_W    = 63;   // timestamp
  localparam int FREQ_W  = 32;   // counter frequency register
  localparam int MS_W    = 48;   // Q32.16 millisecond values
  localparam int FRAC_W  = 16;   // fraction bits of Q32.16
  localparam int FC_W    = 7;    // fill count field

  // delta * 1000 needs 10 more bits; the 16 fraction bits follow
  localparam int PROD_W  = TS_W + 10;
  localparam int DIVN_W  = PROD_W + FRAC_W;

  localparam int WINDOW_DEF = 64;

  localparam logic [MS_W-1:0]   MS_MAX     = {MS_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;

  // Input commands
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_END   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_PROD,
    S_MS_GO,
    S_MS_WAIT,
    S_WRITE,
    S_WALK,
    S_AVG_GO,
    S_AVG_WAIT,
    S_LOAD
  } ftws_state_t;

  // Controller to datapath
  typedef struct packed {
    logic cap_begin;
    logic cap_end;
    logic mul;
    logic prod;
    logic div_start;
    logic div_avg;
    logic ms_load;
    logic ram_write;
    logic walk_init;
    logic walk_step;
    logic out_load;
  } ftws_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic walk_done;
  } ftws_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ftws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ftws_ram #(
  parameter  int WIDTH = 48,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ftws_div.sv -----
// Bit-serial restoring divider with a 48-bit saturating quotient.
`default_nettype none

module ftws_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ftws_pkg::DIVN_W-1:0]   dividend,
  input  logic [ftws_pkg::FREQ_W-1:0]   divisor,
  output logic [ftws_pkg::MS_W-1:0]     quotient,
  output logic                          done
);

  localparam int CW = $clog2(ftws_pkg::DIVN_W);
  localparam logic [CW-1:0] LAST = CW'(ftws_pkg::DIVN_W - 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [ftws_pkg::DIVN_W-1:0]   num_r, num_nxt;
  logic [ftws_pkg::FREQ_W-1:0]   den_r, den_nxt;
  logic [ftws_pkg::FREQ_W-1:0]   rem_r, rem_nxt;
  logic [ftws_pkg::MS_W-1:0]     quo_r, quo_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [ftws_pkg::FREQ_W:0]     trial;
  logic [ftws_pkg::FREQ_W:0]     diff;
  logic                          ge;

  always_comb begin
    trial = {rem_r, num_r[ftws_pkg::DIVN_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      num_nxt = {num_r[ftws_pkg::DIVN_W-2:0], 1'b0};
      rem_nxt = ge ? diff[ftws_pkg::FREQ_W-1:0] : trial[ftws_pkg::FREQ_W-1:0];
      quo_nxt = {quo_r[ftws_pkg::MS_W-2:0], ge};
      // a one leaving the top of the quotient means it no longer fits
      ovf_nxt = ovf_r | quo_r[ftws_pkg::MS_W-1];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign quotient = ovf_r ? ftws_pkg::MS_MAX : quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ----- rtl/ftws_dp.sv -----
// Datapath: timestamp capture, scaling, divider, ring RAM, window walk and result registers.
`default_nettype none

module ftws_dp #(
  parameter int WINDOW = ftws_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ftws_pkg::ftws_cmd_t           cmd,
  output ftws_pkg::ftws_sts_t           sts,
  input  logic                          cfg_wr_en,
  input  logic [ftws_pkg::FREQ_W-1:0]   cfg_wr_data,
  input  logic [ftws_pkg::TS_W-1:0]     in_timestamp,
  output logic [ftws_pkg::MS_W-1:0]     out_last_ms,
  output logic [ftws_pkg::MS_W-1:0]     out_avg_ms,
  output logic [ftws_pkg::MS_W-1:0]     out_min_ms,
  output logic [ftws_pkg::MS_W-1:0]     out_max_ms,
  output logic [ftws_pkg::FC_W-1:0]     out_fill_count
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = ftws_pkg::MS_W + CNT_W;
  localparam int MS_W  = ftws_pkg::MS_W;
  localparam int TS_W  = ftws_pkg::TS_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

  logic [ftws_pkg::FREQ_W-1:0] freq_r;
  logic [TS_W-1:0]             frame_start_r;
  logic [TS_W-1:0]             delta_r;
  logic [TS_W+4:0]             mul24_r;
  logic [ftws_pkg::PROD_W-1:0] prod_r;
  logic [MS_W-1:0]             ms_r;
  logic [IDX_W-1:0]            wi_r;
  logic [CNT_W-1:0]            filled_r;
  logic [CNT_W-1:0]            rd_idx_r;
  logic                        rd_pend_r;
  logic [SUM_W-1:0]            sum_r;
  logic [MS_W-1:0]             min_r;
  logic [MS_W-1:0]             max_r;

  logic [ftws_pkg::DIVN_W-1:0] div_num;
  logic [ftws_pkg::FREQ_W-1:0] div_den;
  logic [MS_W-1:0]             div_q;
  logic                        div_done;
  logic [MS_W-1:0]             ram_q;
  logic                        rd_more;
  logic [CNT_W+ftws_pkg::FC_W-1:0] fc_ext;

  // Configuration and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r        <= ftws_pkg::FREQ_RESET;
      frame_start_r <= '0;
      wi_r          <= '0;
      filled_r      <= '0;
      rd_pend_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        freq_r <= cfg_wr_data;
      end
      if (cmd.cap_begin) begin
        frame_start_r <= in_timestamp;
      end
      if (cmd.ram_write) begin
        wi_r <= (wi_r == IDX_LAST) ? '0 : wi_r + 1'b1;
        if (filled_r != CNT_FULL) begin
          filled_r <= filled_r + 1'b1;
        end
      end
      if (cmd.walk_init) begin
        rd_pend_r <= 1'b0;
      end else if (cmd.walk_step) begin
        rd_pend_r <= rd_more;
      end
    end
  end

  assign rd_more = (rd_idx_r != filled_r);

  // Elapsed ticks, then delta * 1000 as delta * 1024 - delta * 24
  always_ff @(posedge clk) begin
    if (cmd.cap_end) begin
      delta_r <= in_timestamp - frame_start_r;
    end
    if (cmd.mul) begin
      mul24_r <= {1'b0, delta_r, 4'b0} + {2'b0, delta_r, 3'b0};
    end
    if (cmd.prod) begin
      prod_r <= {delta_r, 10'b0} - {5'b0, mul24_r};
    end
    if (cmd.ms_load) begin
      ms_r <= (freq_r == '0) ? '0 : div_q;
    end
  end

  // Shared divider: milliseconds first, then the window mean
  always_comb begin
    if (cmd.div_avg) begin
      div_num = {{(ftws_pkg::DIVN_W - SUM_W){1'b0}}, sum_r};
      div_den = {{(ftws_pkg::FREQ_W - CNT_W){1'b0}}, filled_r};
    end else begin
      div_num = {prod_r, {ftws_pkg::FRAC_W{1'b0}}};
      div_den = freq_r;
    end
  end

  ftws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  ftws_ram #(
    .WIDTH (MS_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.ram_write),
    .wr_addr (wi_r),
    .wr_data (ms_r),
    .rd_en   (cmd.walk_step && rd_more),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (ram_q)
  );

  // Window walk: one read a cycle, each read accumulated in the cycle after
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      rd_idx_r <= '0;
      sum_r    <= '0;
      min_r    <= ms_r;
      max_r    <= ms_r;
    end else if (cmd.walk_step) begin
      if (rd_more) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (rd_pend_r) begin
        sum_r <= sum_r + {{(SUM_W - MS_W){1'b0}}, ram_q};
        if (ram_q < min_r) begin
          min_r <= ram_q;
        end
        if (ram_q > max_r) begin
          max_r <= ram_q;
        end
      end
    end
  end

  assign sts.div_done  = div_done;
  assign sts.walk_done = !rd_more && !rd_pend_r;

  assign fc_ext = {{ftws_pkg::FC_W{1'b0}}, filled_r};

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_ms    <= ms_r;
      out_avg_ms     <= div_q;
      out_min_ms     <= min_r;
      out_max_ms     <= max_r;
      out_fill_count <= fc_ext[ftws_pkg::FC_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ftws_ctrl.sv -----
// Controller state machine and result valid of the frame-time window statistics block.
`default_nettype none

module ftws_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_command,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  ftws_pkg::ftws_sts_t   sts,
  output ftws_pkg::ftws_cmd_t   cmd
);

  ftws_pkg::ftws_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  in_xfer;
  logic                  out_free;

  assign in_stall = (state_r != ftws_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ftws_pkg::S_IDLE: begin
        if (in_xfer && (in_command == ftws_pkg::CMD_END)) begin
          state_nxt = ftws_pkg::S_MUL;
        end
      end
      ftws_pkg::S_MUL:     state_nxt = ftws_pkg::S_PROD;
      ftws_pkg::S_PROD:    state_nxt = ftws_pkg::S_MS_GO;
      ftws_pkg::S_MS_GO:   state_nxt = ftws_pkg::S_MS_WAIT;
      ftws_pkg::S_MS_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ftws_pkg::S_WRITE;
        end
      end
      ftws_pkg::S_WRITE:   state_nxt = ftws_pkg::S_WALK;
      ftws_pkg::S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = ftws_pkg::S_AVG_GO;
        end
      end
      ftws_pkg::S_AVG_GO:  state_nxt = ftws_pkg::S_AVG_WAIT;
      ftws_pkg::S_AVG_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ftws_pkg::S_LOAD;
        end
      end
      ftws_pkg::S_LOAD: begin
        if (out_free) begin
          state_nxt = ftws_pkg::S_IDLE;
        end
      end
      default:             state_nxt = ftws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ftws_pkg::S_IDLE: begin
        cmd.cap_begin = in_xfer && (in_command == ftws_pkg::CMD_BEGIN);
        cmd.cap_end   = in_xfer && (in_command == ftws_pkg::CMD_END);
      end
      ftws_pkg::S_MUL:      cmd.mul = 1'b1;
      ftws_pkg::S_PROD:     cmd.prod = 1'b1;
      ftws_pkg::S_MS_GO:    cmd.div_start = 1'b1;
      ftws_pkg::S_MS_WAIT:  cmd.ms_load = sts.div_done;
      ftws_pkg::S_WRITE: begin
        cmd.ram_write = 1'b1;
        cmd.walk_init = 1'b1;
      end
      ftws_pkg::S_WALK:     cmd.walk_step = 1'b1;
      ftws_pkg::S_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = 1'b1;
      end
      ftws_pkg::S_AVG_WAIT: cmd.div_avg = 1'b1;
      ftws_pkg::S_LOAD:     cmd.out_load = out_free;
      default:              cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ftws_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/frame_time_window_stats.sv -----
// Top level of the frame-time window statistics block.
`default_nettype none

// Frame-time monitor. A begin transfer (command 0) latches the timestamp and
// gives no result. An end transfer (command 1) measures the ticks since the
// latched timestamp modulo 2^63, converts them to milliseconds in unsigned
// Q32.16 as ticks * 1000 * 65536 / cfg frequency (truncated, saturating at
// 2^48 - 1, zero when the frequency is zero), stores the value in a ring of
// the last WINDOW frame times and returns last, mean, minimum, maximum and
// fill count. A bit-serial divider runs twice, 89 steps each, once for the
// conversion and once for the mean, and the ring RAM is walked one entry a
// cycle through its single read port. The input is stalled while an end
// event is in work; a finished result sits in an output register, so the
// next item is taken while it waits. Write the frequency only while the
// block is idle.
module frame_time_window_stats #(
  parameter int WINDOW = ftws_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [ftws_pkg::FREQ_W-1:0]   cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [ftws_pkg::TS_W-1:0]     in_timestamp,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ftws_pkg::MS_W-1:0]     out_last_ms,
  output logic [ftws_pkg::MS_W-1:0]     out_avg_ms,
  output logic [ftws_pkg::MS_W-1:0]     out_min_ms,
  output logic [ftws_pkg::MS_W-1:0]     out_max_ms,
  output logic [ftws_pkg::FC_W-1:0]     out_fill_count
);

  ftws_pkg::ftws_cmd_t cmd;
  ftws_pkg::ftws_sts_t sts;

  // Sequence each end event: scale, divide, write, walk, divide, hand over
  ftws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold the arithmetic, the ring and the result register
  ftws_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_timestamp   (in_timestamp),
    .out_last_ms    (out_last_ms),
    .out_avg_ms     (out_avg_ms),
    .out_min_ms     (out_min_ms),
    .out_max_ms     (out_max_ms),
    .out_fill_count (out_fill_count)
  );

  // The mean of the window lies between its extremes
  a_avg_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_ms <= out_avg_ms) && (out_avg_ms <= out_max_ms))
    else $error("window mean outside minimum and maximum");

  // This frame is part of the window, so it lies between the extremes too
  a_last_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_ms <= out_last_ms) && (out_last_ms <= out_max_ms))
    else $error("last frame time outside minimum and maximum");

  // An end transfer starts work that stalls the input
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == ftws_pkg::CMD_END) |=> in_stall)
    else $error("input not stalled after an end transfer");

endmodule

`default_nettype wire
